// ===== design/lqs_pkg.sv =====
// ----------------------------------------------------------------------------
// lqs_pkg: shared types and constants for the link quality monitor
// Command codes, reset values, delivery percentage codes and queue word types.
// ----------------------------------------------------------------------------
package lqs_pkg;

  // default sizes
  localparam int TOTAL_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // command codes
  localparam logic [1:0] CMD_RX     = 2'd0;
  localparam logic [1:0] CMD_RX_SEQ = 2'd1;
  localparam logic [1:0] CMD_SNAP   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // register and window reset values
  localparam logic [7:0]        DECAY_RESET     = 8'd10;
  localparam logic signed [7:0] RSSI_LOW_RESET  = 8'sh7F;
  localparam logic signed [7:0] RSSI_HIGH_RESET = 8'sh80;

  // delivery percentage codes
  localparam logic [7:0] PDR_NONE = 8'hFF;
  localparam logic [7:0] PDR_CAP  = 8'd100;

  // one input word as held in the queue
  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [7:0] rssi;
    logic [7:0]        mode;
    logic [31:0]       seq;
  } lqs_item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic      valid;
    lqs_item_t item;
  } lqs_qhead_t;

endpackage

// ===== design/lqs_if.sv =====
// ----------------------------------------------------------------------------
// lqs_if: channel interfaces of the link quality monitor
// Input word channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------

// input words
interface lqs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [7:0] rssi;
  logic [7:0]        mode;
  logic [31:0]       seq;

  modport source (output valid, cmd, rssi, mode, seq, input ready);
  modport sink   (input valid, cmd, rssi, mode, seq, output ready);
endinterface

// result words
interface lqs_out_if;
  logic              valid;
  logic              ready;
  logic [15:0]       rx_count;
  logic signed [7:0] rssi_avg;
  logic signed [7:0] rssi_min;
  logic signed [7:0] rssi_max;
  logic [7:0]        last_mode_out;
  logic [7:0]        pdr_percent;

  modport source (output valid, rx_count, rssi_avg, rssi_min, rssi_max, last_mode_out,
                  pdr_percent, input ready);
  modport sink   (input valid, rx_count, rssi_avg, rssi_min, rssi_max, last_mode_out,
                  pdr_percent, output ready);
endinterface

// decay period register writes
interface lqs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== design/lqs_front.sv =====
// ----------------------------------------------------------------------------
// lqs_front: input side of the link quality monitor
// Accepts words, drops the unused command and queues the rest for the back end.
// ----------------------------------------------------------------------------
module lqs_front #(
  parameter int DEPTH = lqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  lqs_in_if.sink             item,
  output lqs_pkg::lqs_qhead_t head,
  input  logic               pop
);
  import lqs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lqs_item_t        store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;

  // classify: only commands with an effect enter the queue
  assign item.ready = (fill != CNT_W'(DEPTH));
  assign push       = item.valid && item.ready && (item.cmd != CMD_UNUSED);

  assign head.valid = (fill != '0);
  assign head.item  = store[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= '{cmd: item.cmd, rssi: item.rssi, mode: item.mode, seq: item.seq};
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== design/lqs_div.sv =====
// ----------------------------------------------------------------------------
// lqs_div: unsigned restoring divider, one quotient bit per cycle
// Quotient is valid from the done pulse until the next start.
// ----------------------------------------------------------------------------
module lqs_div #(
  parameter int N_W = 32,
  parameter int D_W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);
  localparam int CW = $clog2(N_W + 1);

  logic [D_W-1:0] rem;
  logic [D_W-1:0] dvs;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [D_W:0]   shifted;
  logic [D_W:0]   diff;

  // one trial subtraction
  assign shifted = {rem, quotient[N_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= diff[D_W] ? shifted[D_W-1:0] : diff[D_W-1:0];
      quotient <= {quotient[N_W-2:0], ~diff[D_W]};
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/lqs_back.sv =====
// ----------------------------------------------------------------------------
// lqs_back: statistics engine of the link quality monitor
// Folds receive words into the window, sequence words into totals; a snapshot
// runs the average and delivery divisions and fills the result register.
// ----------------------------------------------------------------------------
module lqs_back #(
  parameter int TOTAL_WIDTH = lqs_pkg::TOTAL_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  lqs_cfg_if.sink            cfg,
  input  lqs_pkg::lqs_qhead_t head,
  output logic               pop,
  lqs_out_if.source          result
);
  import lqs_pkg::*;

  localparam int PW = TOTAL_WIDTH + 7;
  localparam int SW = ((TOTAL_WIDTH > 32) ? TOTAL_WIDTH : 32) + 1;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_DIVIDE  = 2'd1;
  localparam logic [1:0] ST_DELIVER = 2'd2;

  // register and state
  logic [7:0]             decay_period;
  logic [31:0]            window_count;
  logic [31:0]            rssi_total;
  logic signed [7:0]      rssi_low;
  logic signed [7:0]      rssi_high;
  logic [7:0]             last_mode;
  logic                   seq_seen;
  logic [TOTAL_WIDTH-1:0] expected_total;
  logic [TOTAL_WIDTH-1:0] received_total;
  logic [31:0]            last_seq;
  logic [7:0]             snapshots_since_decay;
  logic [1:0]             state;
  logic                   avg_fin;
  logic                   pdr_fin;

  // snapshot capture
  logic [15:0]       snap_count;
  logic              snap_empty;
  logic              snap_neg;
  logic signed [7:0] snap_min;
  logic signed [7:0] snap_max;
  logic [7:0]        snap_mode;
  logic              snap_pdr_ok;

  // result register
  logic              out_valid;
  logic [15:0]       out_count;
  logic signed [7:0] out_avg;
  logic signed [7:0] out_min;
  logic signed [7:0] out_max;
  logic [7:0]        out_mode;
  logic [7:0]        out_pdr;

  logic                   rx_fire;
  logic                   seq_fire;
  logic                   snap_fire;
  logic [31:0]            gap;
  logic [SW-1:0]          exp_sum;
  logic [TOTAL_WIDTH-1:0] exp_add;
  logic [TOTAL_WIDTH-1:0] rec_add;
  logic [TOTAL_WIDTH:0]   exp_inc;
  logic [TOTAL_WIDTH:0]   rec_inc;
  logic [7:0]             ssd_inc;
  logic                   decay_hit;
  logic [31:0]            sum_abs;
  logic [PW-1:0]          rec_ext;
  logic [PW-1:0]          rec_x100;
  logic                   avg_done;
  logic                   pdr_done;
  logic [31:0]            avg_q;
  logic [PW-1:0]          pdr_q;
  logic                   out_free;
  logic [7:0]             avg_mag;
  logic signed [7:0]      avg_val;
  logic [7:0]             pdr_val;

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_period <= DECAY_RESET;
    end else if (cfg.valid) begin
      decay_period <= cfg.data;
    end
  end

  // command decode at the queue head
  assign pop       = (state == ST_IDLE) && head.valid;
  assign rx_fire   = pop && ((head.item.cmd == CMD_RX) || (head.item.cmd == CMD_RX_SEQ));
  assign seq_fire  = pop && (head.item.cmd == CMD_RX_SEQ);
  assign snap_fire = pop && (head.item.cmd == CMD_SNAP);

  // delivery totals: saturating adds and round-up halving
  assign gap     = (head.item.seq > last_seq) ? (head.item.seq - last_seq) : 32'd1;
  assign exp_sum = SW'(expected_total) + SW'(gap);
  assign exp_add = (|exp_sum[SW-1:TOTAL_WIDTH]) ? '1 : exp_sum[TOTAL_WIDTH-1:0];
  assign rec_add = (&received_total) ? received_total
                                     : received_total + TOTAL_WIDTH'(1);
  assign exp_inc = {1'b0, expected_total} + (TOTAL_WIDTH + 1)'(1);
  assign rec_inc = {1'b0, received_total} + (TOTAL_WIDTH + 1)'(1);

  assign ssd_inc   = snapshots_since_decay + 8'd1;
  assign decay_hit = (ssd_inc >= decay_period);

  // division operands
  assign sum_abs  = rssi_total[31] ? (~rssi_total + 32'd1) : rssi_total;
  assign rec_ext  = PW'(received_total);
  assign rec_x100 = (rec_ext << 6) + (rec_ext << 5) + (rec_ext << 2);

  lqs_div #(.N_W(32), .D_W(32)) u_avg_div (
    .clk      (clk),
    .rst      (rst),
    .start    (snap_fire),
    .dividend (sum_abs),
    .divisor  (window_count),
    .done     (avg_done),
    .quotient (avg_q)
  );

  lqs_div #(.N_W(PW), .D_W(TOTAL_WIDTH)) u_pdr_div (
    .clk      (clk),
    .rst      (rst),
    .start    (snap_fire),
    .dividend (rec_x100),
    .divisor  (expected_total),
    .done     (pdr_done),
    .quotient (pdr_q)
  );

  // window and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      window_count          <= '0;
      rssi_total            <= '0;
      rssi_low              <= RSSI_LOW_RESET;
      rssi_high             <= RSSI_HIGH_RESET;
      last_mode             <= '0;
      seq_seen              <= 1'b0;
      expected_total        <= '0;
      received_total        <= '0;
      last_seq              <= '0;
      snapshots_since_decay <= '0;
    end else begin
      if (rx_fire) begin
        window_count <= window_count + 32'd1;
        rssi_total   <= rssi_total + {{24{head.item.rssi[7]}}, head.item.rssi};
        if (head.item.rssi < rssi_low) begin
          rssi_low <= head.item.rssi;
        end
        if (head.item.rssi > rssi_high) begin
          rssi_high <= head.item.rssi;
        end
        last_mode <= head.item.mode;
      end
      if (seq_fire) begin
        if (!seq_seen) begin
          seq_seen       <= 1'b1;
          expected_total <= TOTAL_WIDTH'(1);
          received_total <= TOTAL_WIDTH'(1);
        end else begin
          expected_total <= exp_add;
          received_total <= rec_add;
        end
        last_seq <= head.item.seq;
      end
      if (snap_fire) begin
        window_count <= '0;
        rssi_total   <= '0;
        rssi_low     <= RSSI_LOW_RESET;
        rssi_high    <= RSSI_HIGH_RESET;
        if (decay_hit) begin
          snapshots_since_decay <= '0;
          if (seq_seen) begin
            expected_total <= exp_inc[TOTAL_WIDTH:1];
            received_total <= rec_inc[TOTAL_WIDTH:1];
          end
        end else begin
          snapshots_since_decay <= ssd_inc;
        end
      end
    end
  end

  // snapshot capture of the fields that need no division
  always_ff @(posedge clk) begin
    if (snap_fire) begin
      snap_count  <= window_count[15:0];
      snap_empty  <= (window_count == '0);
      snap_neg    <= rssi_total[31];
      snap_min    <= rssi_low;
      snap_max    <= rssi_high;
      snap_mode   <= last_mode;
      snap_pdr_ok <= seq_seen && (expected_total != '0);
    end
  end

  // snapshot sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      avg_fin <= 1'b0;
      pdr_fin <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (snap_fire) begin
            state   <= ST_DIVIDE;
            avg_fin <= 1'b0;
            pdr_fin <= 1'b0;
          end
        end
        ST_DIVIDE: begin
          if (avg_done) avg_fin <= 1'b1;
          if (pdr_done) pdr_fin <= 1'b1;
          if ((avg_fin || avg_done) && (pdr_fin || pdr_done)) begin
            state <= ST_DELIVER;
          end
        end
        ST_DELIVER: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result fields
  assign out_free = !out_valid || result.ready;
  assign avg_mag  = avg_q[7:0];
  assign avg_val  = snap_empty ? 8'sd0 : (snap_neg ? 8'(8'd0 - avg_mag) : avg_mag);
  assign pdr_val  = !snap_pdr_ok ? PDR_NONE :
                    (pdr_q > PW'(PDR_CAP)) ? PDR_CAP : pdr_q[7:0];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DELIVER) && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DELIVER) && out_free) begin
      out_count <= snap_count;
      out_avg   <= avg_val;
      out_min   <= snap_empty ? 8'sd0 : snap_min;
      out_max   <= snap_empty ? 8'sd0 : snap_max;
      out_mode  <= snap_mode;
      out_pdr   <= pdr_val;
    end
  end

  assign result.valid         = out_valid;
  assign result.rx_count      = out_count;
  assign result.rssi_avg      = out_avg;
  assign result.rssi_min      = out_min;
  assign result.rssi_max      = out_max;
  assign result.last_mode_out = out_mode;
  assign result.pdr_percent   = out_pdr;

endmodule

// ===== design/link_quality_stats.sv =====
// ----------------------------------------------------------------------------
// link_quality_stats: radio link quality monitor
// Receive words fold RSSI into a window; a snapshot word emits the window
// statistics and the delivery percentage.
// ----------------------------------------------------------------------------
// Receive word: folded into the window in the cycle that it leaves the queue.
// Snapshot word: the result is registered once both bit-serial dividers are
// done and the result register is free.
// The engine takes one word per cycle between snapshots; the input queue
// keeps accepting while a snapshot divides or a result waits, until it is full.
// Synchronous reset clears the window, totals, queue and result register and
// loads decay_period with 10; no clearing pass follows.
module link_quality_stats #(
  parameter int TOTAL_WIDTH = lqs_pkg::TOTAL_WIDTH_DEF,
  parameter int QUEUE_DEPTH = lqs_pkg::QUEUE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  lqs_in_if.sink    item,
  lqs_cfg_if.sink   cfg,
  lqs_out_if.source result
);
  import lqs_pkg::*;

  lqs_qhead_t head;
  logic       pop;

  // front end: classify and queue
  lqs_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .head (head),
    .pop  (pop)
  );

  // back end: statistics and result
  lqs_back #(.TOTAL_WIDTH(TOTAL_WIDTH)) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

// ===== design/lqs_checker.sv =====
// ----------------------------------------------------------------------------
// lqs_checker: port-level checks of the link quality monitor
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module lqs_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] rssi_min,
  input logic signed [7:0] rssi_max,
  input logic [7:0]        pdr_percent
);
  import lqs_pkg::*;

  // a stalled result word stays valid with its percentage and minimum unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pdr_percent) && $stable(rssi_min))
    else $error("result word changed while stalled");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // percentage is capped or marks missing sequence data
  a_pdr: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pdr_percent <= PDR_CAP) || (pdr_percent == PDR_NONE))
    else $error("delivery percentage out of range");

  // window minimum never above maximum
  a_minmax: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rssi_min <= rssi_max)
    else $error("rssi minimum above maximum");

endmodule

bind link_quality_stats lqs_checker u_lqs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .rssi_min    (result.rssi_min),
  .rssi_max    (result.rssi_max),
  .pdr_percent (result.pdr_percent)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for link_quality_stats
// A short table of directed words, then random phases under different decay
// periods. Each accepted word goes through a local link statistics model, and
// every result word is checked field by field against the oldest report that
// the model expects.
// ----------------------------------------------------------------------------
module tb_top;
  import lqs_pkg::*;

  localparam int CLK_PERIOD    = 2;
  localparam int RESET_CYCLES  = 12;
  localparam int TOTAL_W       = TOTAL_WIDTH_DEF;
  localparam logic [63:0] TOTAL_MAX = (64'd1 << TOTAL_W) - 64'd1;
  localparam int SNAP_LATENCY  = 43;
  localparam int SETTLE_CYCLES = SNAP_LATENCY + 20;
  localparam int IDLE_PCT      = 36;
  localparam int RANDOM_WORDS  = 1400;
  localparam int NUM_PHASES    = 6;
  localparam int PRINT_LIMIT   = 40;

  // one snapshot report as seen on the result channel
  typedef struct {
    logic [15:0]       rx_count;
    logic signed [7:0] rssi_avg;
    logic signed [7:0] rssi_min;
    logic signed [7:0] rssi_max;
    logic [7:0]        last_mode;
    logic [7:0]        pdr;
  } link_report_t;

  // directed table row; want is used only when fixed is set
  typedef struct {
    logic [1:0]        cmd;
    logic signed [7:0] rssi;
    logic [7:0]        mode;
    logic [31:0]       seq;
    bit                fixed;
    link_report_t      want;
  } stim_row_t;

  localparam link_report_t NO_REPORT = '{16'd0, 8'sd0, 8'sd0, 8'sd0, 8'd0, 8'd0};
  localparam link_report_t EMPTY_NO_SEQ = '{16'd0, 8'sd0, 8'sd0, 8'sd0, 8'd0, PDR_NONE};
  localparam int NUM_ROWS = 20;

  logic clk = 1'b0;
  logic rst;
  bit   no_idle;
  int   mismatches;

  lqs_in_if  in_if ();
  lqs_cfg_if cfg_if ();
  lqs_out_if out_if ();

  link_quality_stats dut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_if),
    .cfg    (cfg_if),
    .result (out_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // link statistics model state
  logic [31:0]       win_count;
  logic [31:0]       win_sum;
  logic signed [7:0] win_low;
  logic signed [7:0] win_high;
  logic [7:0]        mode_seen;
  bit                seq_valid;
  logic [63:0]       exp_pkts;
  logic [63:0]       got_pkts;
  logic [31:0]       prev_seq;
  logic [7:0]        snap_count;
  logic [7:0]        decay_reg;
  logic [31:0]       seq_cursor;

  link_report_t pending_reports [$];

  // directed words: reset state, extremes, unused command, sequence wrap,
  // saturation of the expected total, backward and repeated sequence numbers
  stim_row_t dir_rows [NUM_ROWS] = '{
    '{CMD_SNAP,   8'sd0,   8'd0,   32'd0,         1'b1, EMPTY_NO_SEQ},
    '{CMD_RX,     8'sd127, 8'hFF,  32'd0,         1'b0, NO_REPORT},
    '{CMD_RX,     8'sh80,  8'h00,  32'hFFFF_FFFF, 1'b0, NO_REPORT},
    '{CMD_SNAP,   8'sd0,   8'd0,   32'd0,         1'b1,
      '{16'd2, 8'sd0, 8'sh80, 8'sd127, 8'd0, PDR_NONE}},
    '{CMD_UNUSED, -8'sd5,  8'd77,  32'd123,       1'b0, NO_REPORT},
    '{CMD_SNAP,   8'sd0,   8'd0,   32'd0,         1'b1, EMPTY_NO_SEQ},
    '{CMD_RX_SEQ, -8'sd1,  8'hA5,  32'd0,         1'b0, NO_REPORT},
    '{CMD_RX_SEQ, 8'sd0,   8'h5A,  32'hFFFF_FFFF, 1'b0, NO_REPORT},
    '{CMD_SNAP,   8'sd0,   8'd0,   32'd0,         1'b0, NO_REPORT},
    '{CMD_RX_SEQ, 8'sd100, 8'd1,   32'd5,         1'b0, NO_REPORT},
    '{CMD_RX_SEQ, 8'sd100, 8'd2,   32'd5,         1'b0, NO_REPORT},
    '{CMD_RX_SEQ, 8'sd55,  8'd3,   32'h8000_0000, 1'b0, NO_REPORT},
    '{CMD_RX,     -8'sd77, 8'hC3,  32'h5555_5555, 1'b0, NO_REPORT},
    '{CMD_SNAP,   8'sd0,   8'd0,   32'hAAAA_AAAA, 1'b0, NO_REPORT},
    '{CMD_RX,     8'sh80,  8'h0F,  32'd0,         1'b0, NO_REPORT},
    '{CMD_RX,     8'sh80,  8'hF0,  32'd0,         1'b0, NO_REPORT},
    '{CMD_RX,     8'sd127, 8'h3C,  32'd0,         1'b0, NO_REPORT},
    '{CMD_SNAP,   8'sd0,   8'd0,   32'd0,         1'b0, NO_REPORT},
    '{CMD_UNUSED, 8'sd127, 8'hFF,  32'hFFFF_FFFF, 1'b0, NO_REPORT},
    '{CMD_SNAP,   8'sd0,   8'd0,   32'd0,         1'b0, NO_REPORT}
  };

  function automatic logic [63:0] sat_total(input logic [63:0] v);
    return (v > TOTAL_MAX) ? TOTAL_MAX : v;
  endfunction

  // advance the model by one accepted word; a snapshot yields a report
  function automatic void predict_word(input lqs_item_t w, output bit emits,
                                       output link_report_t r);
    logic signed [7:0] rssi_in;
    logic [31:0]       gap;
    logic [63:0]       pct;
    longint            sum_s;
    longint            avg_l;
    emits   = 1'b0;
    r       = NO_REPORT;
    rssi_in = w.rssi;
    case (w.cmd)
      CMD_RX, CMD_RX_SEQ: begin
        win_count = win_count + 32'd1;
        win_sum   = win_sum + {{24{rssi_in[7]}}, rssi_in};
        if (rssi_in < win_low) win_low = rssi_in;
        if (rssi_in > win_high) win_high = rssi_in;
        mode_seen = w.mode;
        if (w.cmd == CMD_RX_SEQ) begin
          if (!seq_valid) begin
            seq_valid = 1'b1;
            exp_pkts  = 64'd1;
            got_pkts  = 64'd1;
          end else begin
            // a non-positive gap counts as one expected packet
            gap      = (w.seq > prev_seq) ? w.seq - prev_seq : 32'd1;
            exp_pkts = sat_total(exp_pkts + {32'd0, gap});
            got_pkts = sat_total(got_pkts + 64'd1);
          end
          prev_seq = w.seq;
        end
      end
      CMD_SNAP: begin
        emits      = 1'b1;
        r.rx_count = win_count[15:0];
        r.last_mode = mode_seen;
        r.pdr      = PDR_NONE;
        if (win_count != 32'd0) begin
          // signed sum over unsigned count, truncated toward zero
          sum_s      = signed'({{32{win_sum[31]}}, win_sum});
          avg_l      = sum_s / signed'({32'd0, win_count});
          r.rssi_avg = avg_l[7:0];
          r.rssi_min = win_low;
          r.rssi_max = win_high;
        end
        if (seq_valid && exp_pkts != 64'd0) begin
          pct   = (got_pkts * 64'd100) / exp_pkts;
          r.pdr = (pct > 64'd100) ? PDR_CAP : pct[7:0];
        end
        win_count  = 32'd0;
        win_sum    = 32'd0;
        win_low    = RSSI_LOW_RESET;
        win_high   = RSSI_HIGH_RESET;
        snap_count = snap_count + 8'd1;
        if (snap_count >= decay_reg) begin
          snap_count = 8'd0;
          if (seq_valid) begin
            exp_pkts = (exp_pkts + 64'd1) >> 1;
            got_pkts = (got_pkts + 64'd1) >> 1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // mostly in-order sequence traffic with snapshots, plus gaps, reorders,
  // huge jumps and unused commands
  function automatic lqs_item_t next_random_word();
    lqs_item_t w;
    int        sel;
    int        kind;
    int        pick;
    sel = $urandom_range(99);
    if (sel < 3) w.cmd = CMD_UNUSED;
    else if (sel < 18) w.cmd = CMD_SNAP;
    else if (sel < 30) w.cmd = CMD_RX;
    else w.cmd = CMD_RX_SEQ;
    pick = $urandom_range(9);
    if (pick == 0) w.rssi = 8'sd127;
    else if (pick == 1) w.rssi = 8'sh80;
    else w.rssi = 8'($urandom_range(255));
    w.mode = 8'($urandom_range(255));
    if (w.cmd == CMD_RX_SEQ) begin
      kind = $urandom_range(99);
      if (kind < 80) w.seq = seq_cursor + 32'($urandom_range(1, 3));
      else if (kind < 88) w.seq = seq_cursor - 32'($urandom_range(0, 5));
      else if (kind < 94) w.seq = seq_cursor + 32'($urandom_range(4, 200));
      else if (kind < 97) w.seq = $urandom;
      else w.seq = seq_cursor + 32'hF000_0000 + 32'($urandom_range(0, 65535));
      seq_cursor = w.seq;
    end else begin
      w.seq = $urandom;
    end
    return w;
  endfunction

  // present one word at a falling edge, hold it until taken, then predict
  task automatic push_item(input lqs_item_t w, input bit fixed, input link_report_t want);
    bit           emits;
    link_report_t r;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= w.cmd;
    in_if.rssi  <= w.rssi;
    in_if.mode  <= w.mode;
    in_if.seq   <= w.seq;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_word(w, emits, r);
    if (emits) pending_reports.push_back(fixed ? want : r);
    @(negedge clk);
  endtask

  // drop valid and wait until every report is back and the queue has drained
  task automatic settle_idle();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_decay(input logic [7:0] period);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= period;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    decay_reg = period;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    mismatches++;
  endtask

  // result sink stalls at random except during the no-idle stretch
  always @(negedge clk) begin
    out_if.ready <= !rst && (no_idle || $urandom_range(99) >= IDLE_PCT);
  end

  // compare each result word with the oldest pending report
  always @(posedge clk) begin : check_results
    link_report_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result word", out_if.rx_count, 16'd0);
      end else begin
        want = pending_reports.pop_front();
        if (out_if.rx_count !== want.rx_count)
          report_mismatch("rx_count", out_if.rx_count, want.rx_count);
        if (out_if.rssi_avg !== want.rssi_avg)
          report_mismatch("rssi_avg", 16'(out_if.rssi_avg), 16'(want.rssi_avg));
        if (out_if.rssi_min !== want.rssi_min)
          report_mismatch("rssi_min", 16'(out_if.rssi_min), 16'(want.rssi_min));
        if (out_if.rssi_max !== want.rssi_max)
          report_mismatch("rssi_max", 16'(out_if.rssi_max), 16'(want.rssi_max));
        if (out_if.last_mode_out !== want.last_mode)
          report_mismatch("last_mode_out", 16'(out_if.last_mode_out), 16'(want.last_mode));
        if (out_if.pdr_percent !== want.pdr)
          report_mismatch("pdr_percent", 16'(out_if.pdr_percent), 16'(want.pdr));
      end
    end
  end

  initial begin : stimulus
    logic [7:0] periods [NUM_PHASES];
    lqs_item_t  w;
    int         sent;
    rst          = 1'b1;
    no_idle      = 1'b0;
    mismatches   = 0;
    in_if.valid  = 1'b0;
    in_if.cmd    = CMD_RX;
    in_if.rssi   = 8'sd0;
    in_if.mode   = 8'd0;
    in_if.seq    = 32'd0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = 8'd0;
    win_count    = 32'd0;
    win_sum      = 32'd0;
    win_low      = RSSI_LOW_RESET;
    win_high     = RSSI_HIGH_RESET;
    mode_seen    = 8'd0;
    seq_valid    = 1'b0;
    exp_pkts     = 64'd0;
    got_pkts     = 64'd0;
    prev_seq     = 32'd0;
    snap_count   = 8'd0;
    decay_reg    = DECAY_RESET;
    seq_cursor   = $urandom;
    // extremes of the period, halving on every snapshot, and a few in between
    periods = '{8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom_range(2, 40)), DECAY_RESET};

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed table under the reset decay period
    foreach (dir_rows[i]) begin
      w.cmd  = dir_rows[i].cmd;
      w.rssi = dir_rows[i].rssi;
      w.mode = dir_rows[i].mode;
      w.seq  = dir_rows[i].seq;
      push_item(w, dir_rows[i].fixed, dir_rows[i].want);
    end

    // random phases, each under its own decay period
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_idle();
      write_decay(periods[ph]);
      no_idle = (ph == 2);
      sent = 0;
      while (sent < RANDOM_WORDS / NUM_PHASES) begin
        w = next_random_word();
        push_item(w, 1'b0, NO_REPORT);
        if (w.cmd != CMD_UNUSED) sent++;
      end
    end

    no_idle = 1'b0;
    settle_idle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("[%0t] timeout, %0d reports outstanding", $realtime, pending_reports.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
